// ===== sv/lspg_pkg.sv =====
// Shared types, constants and table functions of the LED strip pattern generator.
`timescale 1ns / 1ps
package lspg_pkg;

  localparam int PIXEL_COUNT_DEF  = 4;
  localparam int SINE_ENTRIES_DEF = 1024;

  typedef enum logic [2:0] {
    MODE_OFF     = 3'd0,
    MODE_BAR     = 3'd1,
    MODE_RAINBOW = 3'd2,
    MODE_SOS     = 3'd3,
    MODE_BLINK   = 3'd4
  } mode_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] pixel_index;
    logic       last_pixel;
    logic       rainbow;
    rgb_t       base;
    logic [31:0] phase;
  } pix_tok_t;

  localparam rgb_t RGB_BLACK  = '{red: 8'd0,   green: 8'd0,   blue: 8'd0};
  localparam rgb_t RGB_BAR    = '{red: 8'd0,   green: 8'd100, blue: 8'd255};
  localparam rgb_t RGB_SOS    = '{red: 8'd255, green: 8'd0,   blue: 8'd0};
  localparam rgb_t RGB_ORANGE = '{red: 8'd255, green: 8'd100, blue: 8'd0};

  localparam logic [9:0] HUM_FOUR  = 10'd750;
  localparam logic [9:0] HUM_THREE = 10'd500;
  localparam logic [9:0] HUM_TWO   = 10'd250;

  localparam int SOS_LEN = 22;
  localparam logic [SOS_LEN-1:0] SOS_ON = 22'b0001010100101010010101;
  localparam logic [4:0] SOS_LAST = 5'(SOS_LEN - 1);

  localparam logic [1:0] BLINK_LAST = 2'd2;

  localparam logic [31:0] HUE_STEP      = 32'd12;
  localparam logic [31:0] PIX_STEP      = 32'd40;
  localparam logic [31:0] TURN_PER_STEP = 32'd13671306;
  localparam logic [2:0][31:0] CH_OFS   = {32'd2870974157, 32'd1435487079, 32'd0};

  localparam logic [63:0] TWO_PI_Q28 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30    = 64'd1073741824;

  function automatic logic [63:0] taylor_div(input logic [63:0] term, input int n);
    logic [63:0] q;
    case (n)
      1:       q = term / 64'd6;
      2:       q = term / 64'd20;
      3:       q = term / 64'd42;
      4:       q = term / 64'd72;
      5:       q = term / 64'd110;
      default: q = term / 64'd156;
    endcase
    return q;
  endfunction

  function automatic logic [7:0] sine_entry(input int unsigned k, input int unsigned entries);
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] rem;
    logic [63:0] f;
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] u;
    logic        neg;
    num = 64'(k) << 32;
    den = 64'(entries);
    rem = '0;
    f   = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem  = rem - den;
        f[b] = 1'b1;
      end
    end
    neg = 1'b0;
    if (f >= 64'h8000_0000) begin
      neg = 1'b1;
      f   = 64'h1_0000_0000 - f;
    end
    if (f > 64'h4000_0000) f = 64'h8000_0000 - f;
    x    = (f * TWO_PI_Q28) >> 30;
    term = x;
    sum  = x;
    for (int n = 1; n <= 6; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = taylor_div(term, n);
      if ((n % 2) == 1) sum = (sum > term) ? sum - term : 64'd0;
      else              sum = sum + term;
    end
    if (sum > ONE_Q30) sum = ONE_Q30;
    u = neg ? ONE_Q30 - sum : ONE_Q30 + sum;
    return 8'((u * 64'd127) >> 30);
  endfunction

endpackage

// ===== sv/lspg_if.sv =====
// Channel interfaces: humidity input, pixel output and mode configuration.
`timescale 1ns / 1ps
interface lspg_in_if;
  logic       valid;
  logic       ready;
  logic [9:0] humidity_tenths;
  modport source (output valid, humidity_tenths, input ready);
  modport sink   (input valid, humidity_tenths, output ready);
endinterface

interface lspg_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] pixel_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       last_pixel;
  modport source (output valid, pixel_index, red, green, blue, last_pixel, input ready);
  modport sink   (input valid, pixel_index, red, green, blue, last_pixel, output ready);
endinterface

interface lspg_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] display_mode;
  modport source (output valid, display_mode, input ready);
  modport sink   (input valid, display_mode, output ready);
endinterface

// ===== sv/led_strip_pattern_generator_unit.sv =====
// Top level of the LED strip pattern generator.
// The first pixel of a tick passes the sequencer registers and stages s1_r, s2_r and s3_r before it is valid.
// Throughput: one pixel per cycle while the output is not stalled, set by the
// single pixel output; the next tick is taken as the last pixel advances.
// Ticks in an undefined mode are taken and give no pixels.
// Reset (synchronous, rst_n low) clears mode, counters and pipeline valids.
`timescale 1ns / 1ps
module led_strip_pattern_generator_unit #(
  parameter int PIXEL_COUNT  = lspg_pkg::PIXEL_COUNT_DEF,
  parameter int SINE_ENTRIES = lspg_pkg::SINE_ENTRIES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  lspg_in_if.sink    in_chan,
  lspg_out_if.source out_chan,
  lspg_cfg_if.sink   cfg_chan
);

  logic [2:0]         mode_r;
  logic               adv;
  lspg_pkg::pix_tok_t tok;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 3'(lspg_pkg::MODE_OFF);
    end else if (cfg_chan.valid) begin
      mode_r <= cfg_chan.display_mode;
    end
  end

  lspg_front #(
    .PIXEL_COUNT (PIXEL_COUNT)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .mode    (mode_r),
    .adv     (adv),
    .tok     (tok)
  );

  lspg_pixel_pipe #(
    .SINE_ENTRIES (SINE_ENTRIES)
  ) u_pipe (
    .clk      (clk),
    .rst_n    (rst_n),
    .tok      (tok),
    .adv      (adv),
    .out_chan (out_chan)
  );

endmodule

// ===== sv/lspg_sine_rom.sv =====
// Sine lookup ROM with registered read data.
`timescale 1ns / 1ps
module lspg_sine_rom #(
  parameter int unsigned DEPTH = lspg_pkg::SINE_ENTRIES_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          en,
  input  logic [AW-1:0] addr,
  output logic [7:0]    data
);

  typedef logic [DEPTH-1:0][7:0] rom_t;

  function automatic rom_t build_rom();
    rom_t t;
    for (int k = 0; k < int'(DEPTH); k++) begin
      t[k] = lspg_pkg::sine_entry(k, DEPTH);
    end
    return t;
  endfunction

  localparam rom_t ROM_TBL = build_rom();

  logic [7:0] data_r;

  always_ff @(posedge clk) begin
    if (en) data_r <= ROM_TBL[addr];
  end

  assign data = data_r;

endmodule

// ===== sv/lspg_front.sv =====
// Tick acceptance, mode counters, item register and pixel sequencer.
`timescale 1ns / 1ps
module lspg_front #(
  parameter int PIXEL_COUNT = lspg_pkg::PIXEL_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  lspg_in_if.sink            in_chan,
  input  logic [2:0]         mode,
  input  logic               adv,
  output lspg_pkg::pix_tok_t tok
);

  localparam int PIX_W = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;

  logic             busy_r, busy_nxt;
  logic [PIX_W-1:0] pix_r, pix_nxt;
  logic [31:0]      hue_r, hue_nxt;
  logic [4:0]       sos_step_r, sos_step_nxt;
  logic             sos_beat_r, sos_beat_nxt;
  logic [1:0]       blink_cnt_r, blink_cnt_nxt;
  logic             blink_lit_r, blink_lit_nxt;

  lspg_pkg::mode_t  item_mode_r;
  logic [2:0]       lit_r;
  logic             flat_on_r;
  logic [31:0]      item_hue_r;

  logic             accept, mode_ok, load, last_pix;
  logic [2:0]       lit_nxt;
  logic             flat_on_nxt;
  logic [31:0]      hue_a;

  assign mode_ok  = (mode <= 3'(lspg_pkg::MODE_BLINK));
  assign last_pix = (pix_r == PIX_W'(PIXEL_COUNT - 1));
  assign in_chan.ready = !busy_r || (adv && last_pix);
  assign accept   = in_chan.valid && in_chan.ready;
  assign load     = accept && mode_ok;

  always_comb begin
    hue_nxt       = hue_r;
    sos_beat_nxt  = sos_beat_r;
    sos_step_nxt  = sos_step_r;
    blink_cnt_nxt = blink_cnt_r;
    blink_lit_nxt = blink_lit_r;
    flat_on_nxt   = 1'b0;
    unique case (mode)
      lspg_pkg::MODE_RAINBOW: hue_nxt = hue_r + lspg_pkg::HUE_STEP;
      lspg_pkg::MODE_SOS: begin
        sos_beat_nxt = !sos_beat_r;
        if (sos_beat_r) begin
          sos_step_nxt = (sos_step_r == lspg_pkg::SOS_LAST) ? 5'd0 : sos_step_r + 5'd1;
        end
        flat_on_nxt = lspg_pkg::SOS_ON[sos_step_nxt];
      end
      lspg_pkg::MODE_BLINK: begin
        if (blink_cnt_r == lspg_pkg::BLINK_LAST) begin
          blink_cnt_nxt = 2'd0;
          blink_lit_nxt = !blink_lit_r;
        end else begin
          blink_cnt_nxt = blink_cnt_r + 2'd1;
        end
        flat_on_nxt = blink_lit_nxt;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (in_chan.humidity_tenths >= lspg_pkg::HUM_FOUR)       lit_nxt = 3'd4;
    else if (in_chan.humidity_tenths >= lspg_pkg::HUM_THREE) lit_nxt = 3'd3;
    else if (in_chan.humidity_tenths >= lspg_pkg::HUM_TWO)   lit_nxt = 3'd2;
    else if (in_chan.humidity_tenths != 10'd0)               lit_nxt = 3'd1;
    else                                                     lit_nxt = 3'd0;
  end

  always_comb begin
    busy_nxt = busy_r;
    pix_nxt  = pix_r;
    if (busy_r && adv) begin
      if (last_pix) begin
        busy_nxt = load;
        pix_nxt  = '0;
      end else begin
        pix_nxt = PIX_W'(pix_r + 1'b1);
      end
    end else if (!busy_r) begin
      busy_nxt = load;
      pix_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pix_r       <= '0;
      hue_r       <= '0;
      sos_step_r  <= '0;
      sos_beat_r  <= 1'b0;
      blink_cnt_r <= '0;
      blink_lit_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      pix_r  <= pix_nxt;
      if (load) begin
        hue_r       <= hue_nxt;
        sos_step_r  <= sos_step_nxt;
        sos_beat_r  <= sos_beat_nxt;
        blink_cnt_r <= blink_cnt_nxt;
        blink_lit_r <= blink_lit_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_mode_r <= lspg_pkg::mode_t'(mode);
      lit_r       <= lit_nxt;
      flat_on_r   <= flat_on_nxt;
      item_hue_r  <= hue_r;
    end
  end

  assign hue_a = item_hue_r + lspg_pkg::PIX_STEP * 32'(pix_r);

  always_comb begin
    tok.valid       = busy_r;
    tok.pixel_index = 2'(pix_r);
    tok.last_pixel  = last_pix;
    tok.rainbow     = (item_mode_r == lspg_pkg::MODE_RAINBOW);
    tok.phase       = hue_a * lspg_pkg::TURN_PER_STEP;
    case (item_mode_r)
      lspg_pkg::MODE_BAR:
        tok.base = (int'(pix_r) < int'(lit_r)) ? lspg_pkg::RGB_BAR : lspg_pkg::RGB_BLACK;
      lspg_pkg::MODE_SOS:
        tok.base = flat_on_r ? lspg_pkg::RGB_SOS : lspg_pkg::RGB_BLACK;
      lspg_pkg::MODE_BLINK:
        tok.base = flat_on_r ? lspg_pkg::RGB_ORANGE : lspg_pkg::RGB_BLACK;
      default:
        tok.base = lspg_pkg::RGB_BLACK;
    endcase
  end

endmodule

// ===== sv/lspg_pixel_pipe.sv =====
// Pixel pipeline: phase offset, ROM index, sine lookup and output register.
`timescale 1ns / 1ps
module lspg_pixel_pipe #(
  parameter int SINE_ENTRIES = lspg_pkg::SINE_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lspg_pkg::pix_tok_t tok,
  output logic               adv,
  lspg_out_if.source         out_chan
);

  localparam int AW     = $clog2(SINE_ENTRIES);
  localparam int EW     = $clog2(SINE_ENTRIES + 1);
  localparam int PROD_W = 32 + EW;

  lspg_pkg::pix_tok_t s1_r, s2_r, s3_r;
  logic [AW-1:0]      idx_nxt [3];
  logic [AW-1:0]      idx_r   [3];
  logic [7:0]         rom_q   [3];

  assign adv = !s3_r.valid || out_chan.ready;

  for (genvar c = 0; c < 3; c++) begin : g_ch
    logic [31:0]     pc;
    logic [PROD_W-1:0] prod;
    assign pc   = s1_r.phase + lspg_pkg::CH_OFS[c];
    assign prod = PROD_W'(pc) * PROD_W'(SINE_ENTRIES);
    assign idx_nxt[c] = prod[32 +: AW];

    lspg_sine_rom #(
      .DEPTH (SINE_ENTRIES),
      .AW    (AW)
    ) u_rom (
      .clk  (clk),
      .en   (adv),
      .addr (idx_r[c]),
      .data (rom_q[c])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
      s2_r.valid <= 1'b0;
      s3_r.valid <= 1'b0;
    end else if (adv) begin
      s1_r <= tok;
      s2_r <= s1_r;
      s3_r <= s2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) idx_r <= idx_nxt;
  end

  assign out_chan.valid       = s3_r.valid;
  assign out_chan.pixel_index = s3_r.pixel_index;
  assign out_chan.last_pixel  = s3_r.last_pixel;
  assign out_chan.red         = s3_r.rainbow ? rom_q[0] : s3_r.base.red;
  assign out_chan.green       = s3_r.rainbow ? rom_q[1] : s3_r.base.green;
  assign out_chan.blue        = s3_r.rainbow ? rom_q[2] : s3_r.base.blue;

endmodule

// ===== sv/lspg_checker.sv =====
// Port-level checks on the pixel output of the pattern generator, with bind.
`timescale 1ns / 1ps
module lspg_checker #(
  parameter int PIXEL_COUNT = lspg_pkg::PIXEL_COUNT_DEF
) (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] pixel_index,
  input logic [7:0] red,
  input logic [7:0] green,
  input logic [7:0] blue,
  input logic       last_pixel
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable({pixel_index, red, green, blue, last_pixel}))
    else $error("stalled pixel changed");

  a_frame_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !last_pixel |=>
      out_valid && (pixel_index == 2'($past(pixel_index) + 2'd1)))
    else $error("frame pixels not contiguous");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && last_pixel |-> pixel_index == 2'(PIXEL_COUNT - 1))
    else $error("last pixel at wrong index");

endmodule

bind led_strip_pattern_generator_unit lspg_checker #(
  .PIXEL_COUNT (PIXEL_COUNT)
) u_lspg_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .pixel_index (out_chan.pixel_index),
  .red         (out_chan.red),
  .green       (out_chan.green),
  .blue        (out_chan.blue),
  .last_pixel  (out_chan.last_pixel)
);
